FILE: src/tga_rle_pkg.sv
// Package with the shared types and codes of the TGA run-length pixel decoder.
package tga_rle_pkg;

  // Packet phase codes.
  localparam logic [1:0] PH_PACKET = 2'd0;
  localparam logic [1:0] PH_RAW    = 2'd1;
  localparam logic [1:0] PH_RUN    = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] REG_IMAGE_WIDTH     = 8'd0;
  localparam logic [7:0] REG_IMAGE_HEIGHT    = 8'd1;
  localparam logic [7:0] REG_BYTES_PER_PIXEL = 8'd2;
  localparam logic [7:0] REG_RLE_MODE        = 8'd3;

  // Packet byte boundary between raw and run packets, and the run offset.
  localparam logic [7:0] RUN_FLAG   = 8'd128;
  localparam logic [7:0] RUN_OFFSET = 8'd127;

  // Pixel size code that selects four-byte pixels.
  localparam logic [2:0] BPP_FOUR = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
  } byte_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0]  reg_index;
    logic [15:0] wdata;
  } cfg_req_t;

endpackage

FILE: src/tga_rle_if.sv
// Valid/ready channel interfaces for byte input, pixel output and configuration.
interface tga_rle_byte_if import tga_rle_pkg::*; ();
  logic      valid;
  logic      ready;
  byte_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tga_rle_pixel_if import tga_rle_pkg::*; ();
  logic       valid;
  logic       ready;
  pixel_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tga_rle_cfg_if import tga_rle_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/tga_rle_pixel_decoder_top.sv
// Top level of the TGA type 2 / type 10 pixel data decoder.
//
// The block takes the pixel data bytes of a truecolor TGA image, one request
// per byte on pixel_in, and gives one request per finished pixel on
// pixel_out, converted from stored B,G,R(,A) order to red, green, blue and
// alpha, with a repeat count for run-length packets and a flag on the
// request that completes the image. The cfg channel writes image width,
// height, bytes per pixel and the run-length mode; it is always ready and
// should be used only while no pixel is in flight.
// A byte is taken in each cycle that pixel_in.valid and pixel_in.ready are both
// high. Bytes are decoded combinationally, a finished pixel is registered into
// the output queue, and the rate is one byte per cycle while the queue has room.
// Results go through a two-entry output queue: when the receiver stalls,
// one more result can be queued while the head waits, and pixel_in.ready
// drops only once both entries are full.
// The pixel count of an image comes from a product register that is updated
// at each geometry write, so no multiply sits in the byte path.
// Synchronous reset clears the registers to width 0, height 0, three bytes
// per pixel, uncompressed mode, and empties the output queue.
module tga_rle_pixel_decoder_top
  import tga_rle_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  tga_rle_byte_if.sink    pixel_in,
  tga_rle_pixel_if.source pixel_out,
  tga_rle_cfg_if.sink     cfg
);

  // Configuration registers.
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  bytes_per_pixel;
  logic        rle_mode;
  logic [31:0] image_pixels;

  // Decoder state.
  logic [31:0] pixels_left;
  logic [1:0]  packet_phase;
  logic [7:0]  raw_pixels_left;
  logic [7:0]  run_length;
  logic [1:0]  byte_position;
  logic [7:0]  color_bytes [3];

  logic [31:0] pixels_left_next;
  logic [1:0]  packet_phase_next;
  logic [7:0]  raw_pixels_left_next;
  logic [7:0]  run_length_next;
  logic [1:0]  byte_position_next;
  logic        color_we;
  logic [1:0]  color_idx;
  logic        res_valid;
  pixel_req_t  res;

  // Output queue.
  pixel_req_t  out_q [2];
  logic [1:0]  out_cnt;

  logic in_acc;
  logic out_pop;
  logic push;
  logic push_head;

  assign in_acc  = pixel_in.valid && pixel_in.ready;
  assign out_pop = pixel_out.valid && pixel_out.ready;
  assign push    = in_acc && res_valid;

  // A new result lands in the head entry when the queue is empty, or when
  // the only queued result leaves in the same cycle.
  assign push_head = push && (out_cnt == 2'd0 || (out_cnt == 2'd1 && out_pop));

  assign pixel_in.ready  = (out_cnt != 2'd2);
  assign pixel_out.valid = (out_cnt != 2'd0);
  assign pixel_out.data  = out_q[0];
  assign cfg.ready       = 1'b1;

  // Configuration writes; the product register follows the new geometry.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= '0;
      image_height    <= '0;
      bytes_per_pixel <= 3'd3;
      rle_mode        <= 1'b0;
      image_pixels    <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.reg_index)
        REG_IMAGE_WIDTH: begin
          image_width  <= cfg.data.wdata;
          image_pixels <= {16'd0, cfg.data.wdata} * {16'd0, image_height};
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg.data.wdata;
          image_pixels <= {16'd0, image_width} * {16'd0, cfg.data.wdata};
        end
        REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg.data.wdata[2:0];
        REG_RLE_MODE:        rle_mode <= cfg.data.wdata[0];
        default: ;
      endcase
    end
  end

  // One byte of decode: packet header handling and pixel assembly.
  always_comb begin
    logic [7:0]  b;
    logic [31:0] left;
    logic [1:0]  last_pos;
    logic        is_pixel_byte;
    logic [7:0]  count;
    logic        done;

    b         = pixel_in.data.data_byte;
    left      = pixels_left;
    last_pos  = (bytes_per_pixel == BPP_FOUR) ? 2'd3 : 2'd2;
    count     = 8'd1;
    done      = 1'b0;
    is_pixel_byte = 1'b0;

    pixels_left_next     = pixels_left;
    packet_phase_next    = packet_phase;
    raw_pixels_left_next = raw_pixels_left;
    run_length_next      = run_length;
    byte_position_next   = byte_position;
    color_we             = 1'b0;
    color_idx            = byte_position;
    res_valid            = 1'b0;
    res                  = '0;

    // A new image starts with a fresh pixel count and packet state.
    if (pixels_left == 32'd0) begin
      left                 = image_pixels;
      pixels_left_next     = image_pixels;
      packet_phase_next    = PH_PACKET;
      raw_pixels_left_next = '0;
      run_length_next      = '0;
      byte_position_next   = '0;
    end

    if (left != 32'd0) begin
      if (!rle_mode) begin
        packet_phase_next    = PH_PACKET;
        raw_pixels_left_next = '0;
        is_pixel_byte        = 1'b1;
      end else if (packet_phase_next == PH_RAW) begin
        is_pixel_byte = 1'b1;
      end else if (packet_phase_next == PH_RUN) begin
        is_pixel_byte = 1'b1;
        count         = run_length_next;
      end else begin
        byte_position_next = '0;
        if (b < RUN_FLAG) begin
          raw_pixels_left_next = b + 8'd1;
          packet_phase_next    = PH_RAW;
        end else begin
          run_length_next   = b - RUN_OFFSET;
          packet_phase_next = PH_RUN;
        end
      end

      if (is_pixel_byte) begin
        if (byte_position_next < last_pos) begin
          color_we           = 1'b1;
          color_idx          = byte_position_next;
          byte_position_next = byte_position_next + 2'd1;
        end else begin
          if ({24'd0, count} > left) begin
            count = left[7:0];
          end
          res_valid        = 1'b1;
          res.red          = (byte_position_next == 2'd2) ? b : color_bytes[2];
          res.green        = color_bytes[1];
          res.blue         = color_bytes[0];
          res.alpha        = (bytes_per_pixel == BPP_FOUR) ? b : 8'd0;
          res.repeat_count = count;
          pixels_left_next = left - {24'd0, count};
          done             = (pixels_left_next == 32'd0);
          res.image_done   = done;
          byte_position_next = '0;

          if (rle_mode && packet_phase_next == PH_RAW) begin
            raw_pixels_left_next = raw_pixels_left_next - 8'd1;
            if (raw_pixels_left_next == 8'd0) begin
              packet_phase_next = PH_PACKET;
            end
          end else if (rle_mode) begin
            packet_phase_next = PH_PACKET;
            run_length_next   = '0;
          end

          if (done) begin
            packet_phase_next    = PH_PACKET;
            raw_pixels_left_next = '0;
            run_length_next      = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_left     <= '0;
      packet_phase    <= PH_PACKET;
      raw_pixels_left <= '0;
      run_length      <= '0;
      byte_position   <= '0;
    end else if (in_acc) begin
      pixels_left     <= pixels_left_next;
      packet_phase    <= packet_phase_next;
      raw_pixels_left <= raw_pixels_left_next;
      run_length      <= run_length_next;
      byte_position   <= byte_position_next;
    end
  end

  // Stored color bytes carry no reset; each is written before it is read.
  always_ff @(posedge clk) begin
    if (in_acc && color_we) begin
      case (color_idx)
        2'd0:    color_bytes[0] <= pixel_in.data.data_byte;
        2'd1:    color_bytes[1] <= pixel_in.data.data_byte;
        2'd2:    color_bytes[2] <= pixel_in.data.data_byte;
        default: ;
      endcase
    end
  end

  // Two-entry output queue, head in entry 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else begin
      case ({push, out_pop})
        2'b10:   out_cnt <= out_cnt + 2'd1;
        2'b01:   out_cnt <= out_cnt - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_head) begin
      out_q[0] <= res;
    end else if (out_pop) begin
      out_q[0] <= out_q[1];
    end
    if (push && !push_head) begin
      out_q[1] <= res;
    end
  end

`ifndef SYNTHESIS
  // The queue never holds more than its two entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    out_cnt != 2'd3)
    else $error("output queue count out of range");

  // A delivered pixel always covers between one and 128 pixels.
  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    pixel_out.valid |-> (pixel_out.data.repeat_count != 8'd0 &&
                         pixel_out.data.repeat_count <= 8'd128))
    else $error("repeat count out of range");

  // The request that completes an image leaves no pixels outstanding.
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (push && res.image_done) |=> (pixels_left == 32'd0 &&
                                  packet_phase == PH_PACKET))
    else $error("image end did not clear the pixel count");
`endif

endmodule
